// ===== rtl/dls_pkg.sv =====
// shared types, constants and the sigmoid table for the dense layer unit
// no dependencies

package dls_pkg;

    // default store sizes
    localparam int DEF_MAX_INPUTS = 16;
    localparam int DEF_MAX_HIDDEN = 16;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // widest weight address over the whole parameter range
    localparam int ADDR_W = 14;

    // configuration register indexes
    localparam logic CFG_IN_COUNT     = 1'b0;
    localparam logic CFG_HIDDEN_COUNT = 1'b1;

    // reset values of the configuration registers
    localparam logic [8:0] IN_COUNT_RESET     = 9'd16;
    localparam logic [6:0] HIDDEN_COUNT_RESET = 7'd16;

    // input action codes
    localparam logic [1:0] ACT_WEIGHT = 2'd0;
    localparam logic [1:0] ACT_BIAS   = 2'd1;
    localparam logic [1:0] ACT_ELEM   = 2'd2;

    // classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_WEIGHT,
        OP_BIAS,
        OP_ELEM
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [ADDR_W-1:0]  addr;
        logic signed [15:0] value;
    } q_entry_t;

    typedef struct packed {
        logic [8:0] in_count;
        logic [6:0] hidden_count;
    } cfg_t;

    typedef logic [15:0] sig_table_t [256];

    // unsigned 64-bit quotient by shift and subtract, used only while building the table
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] dvs);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, dvs}) begin
                r    = r - {1'b0, dvs};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // sigmoid table from a truncated exponential series in Q40
    function automatic sig_table_t build_sig_table();
        sig_table_t  tbl;
        logic [63:0] k;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] v;
        for (int i = 0; i < 128; i++) begin
            k    = 64'(255 - 2 * i);
            term = 64'd1 << 40;
            e    = term;
            for (int n = 1; n < 200; n++) begin
                if (term != 64'd0) begin
                    term = udiv64(term * k, 64'(32 * n));
                    e    = e + term;
                end
            end
            den         = (64'd1 << 40) + e;
            v           = udiv64((64'd65535 << 40) + (den >> 1), den);
            tbl[i]       = v[15:0];
            tbl[255 - i] = 16'(64'd65535 - v);
        end
        return tbl;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

// ===== rtl/dls_queue.sv =====
// short queue of classified words between front and back
// depends on dls_pkg

module dls_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  dls_pkg::q_entry_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output dls_pkg::q_entry_t pop_data
);
    import dls_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    q_entry_t        mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/dls_front.sv =====
// front end: accepts input words, drops ones with no effect, forms store addresses
// depends on dls_pkg

module dls_front #(
    parameter int MAX_INPUTS = dls_pkg::DEF_MAX_INPUTS,
    parameter int MAX_HIDDEN = dls_pkg::DEF_MAX_HIDDEN
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_action,
    input  logic [7:0]        s_row,
    input  logic [5:0]        s_column,
    input  logic signed [15:0] s_value,
    output logic              push_valid,
    input  logic              push_ready,
    output dls_pkg::q_entry_t push_data
);
    import dls_pkg::*;

    localparam int RW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int HW = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
    localparam int AW = (MAX_INPUTS * MAX_HIDDEN > 1) ? $clog2(MAX_INPUTS * MAX_HIDDEN) : 1;

    logic          row_ok, col_ok, keep;
    logic [AW-1:0] w_addr;

    assign s_ready = push_ready;
    assign row_ok  = ({1'b0, s_row} < 9'(MAX_INPUTS));
    assign col_ok  = ({1'b0, s_column} < 7'(MAX_HIDDEN));
    assign w_addr  = AW'(s_row[RW-1:0]) * AW'(MAX_HIDDEN) + AW'(s_column[HW-1:0]);

    // classify the word
    always_comb begin
        keep            = 1'b0;
        push_data.op    = OP_ELEM;
        push_data.addr  = '0;
        push_data.value = s_value;
        case (s_action)
            ACT_WEIGHT: begin
                keep           = row_ok && col_ok;
                push_data.op   = OP_WEIGHT;
                push_data.addr = ADDR_W'(w_addr);
            end
            ACT_BIAS: begin
                keep           = col_ok;
                push_data.op   = OP_BIAS;
                push_data.addr = ADDR_W'(s_column[HW-1:0]);
            end
            ACT_ELEM: begin
                keep = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign push_valid = s_valid && keep;

endmodule

// ===== rtl/dls_back.sv =====
// back end: weight and bias stores, accumulator sweep and sigmoid output
// depends on dls_pkg

module dls_back #(
    parameter int MAX_INPUTS = dls_pkg::DEF_MAX_INPUTS,
    parameter int MAX_HIDDEN = dls_pkg::DEF_MAX_HIDDEN
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  dls_pkg::cfg_t     cfg,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  dls_pkg::q_entry_t pop_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [5:0]        m_hidden_index,
    output logic [15:0]       m_activation,
    output logic              m_last
);
    import dls_pkg::*;

    localparam int RW  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int CW  = $clog2(MAX_INPUTS + 1);
    localparam int HW  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
    localparam int HCW = $clog2(MAX_HIDDEN + 1);
    localparam int AW  = (MAX_INPUTS * MAX_HIDDEN > 1) ? $clog2(MAX_INPUTS * MAX_HIDDEN) : 1;
    localparam int WD  = MAX_INPUTS * MAX_HIDDEN;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MAC     = 3'd1;
    localparam logic [2:0] ST_DRAIN   = 3'd2;
    localparam logic [2:0] ST_OUT_RD  = 3'd3;
    localparam logic [2:0] ST_OUT_SUM = 3'd4;
    localparam logic [2:0] ST_OUT_LUT = 3'd5;

    // stores
    logic [15:0]         wmem [WD];
    logic [15:0]         bmem [MAX_HIDDEN];
    logic [47:0]         amem [MAX_HIDDEN];
    logic [MAX_HIDDEN-1:0] acc_vld_reg;

    logic [2:0]          state_reg, state_next;
    logic [HW-1:0]       j_reg, j_next;
    logic [CW-1:0]       count_reg, count_next;
    logic signed [15:0]  x_reg;

    logic [15:0]         w_rd_reg, b_rd_reg;
    logic [47:0]         a_rd_reg;
    logic                a_vld_reg;

    logic                s1_valid_reg, s2_valid_reg;
    logic [HW-1:0]       s1_idx_reg, s2_idx_reg;
    logic signed [31:0]  prod_reg;
    logic [47:0]         acc_hold_reg;
    logic [7:0]          lut_idx_reg;

    logic                m_valid_reg;
    logic [5:0]          m_idx_reg;
    logic [15:0]         m_act_reg;
    logic                m_last_reg;

    logic [HCW-1:0]      hc_eff;
    logic [CW-1:0]       in_eff;
    logic                at_last_j, issue, out_load, done_clear;
    logic [AW-1:0]       w_rd_addr;
    logic [CW-1:0]       count_inc;
    logic [47:0]         acc_cur, sum;
    logic                under, over;
    logic [7:0]          lut_idx;

    // effective sizes, clamped to the stores
    always_comb begin
        if (cfg.hidden_count == 7'd0) begin
            hc_eff = HCW'(1);
        end else if ({1'b0, cfg.hidden_count} > 8'(MAX_HIDDEN)) begin
            hc_eff = HCW'(MAX_HIDDEN);
        end else begin
            hc_eff = HCW'(cfg.hidden_count);
        end
        if (cfg.in_count == 9'd0) begin
            in_eff = CW'(1);
        end else if ({1'b0, cfg.in_count} > 10'(MAX_INPUTS)) begin
            in_eff = CW'(MAX_INPUTS);
        end else begin
            in_eff = CW'(cfg.in_count);
        end
    end

    assign at_last_j = (HCW'(j_reg) == hc_eff - 1'b1);
    assign count_inc = count_reg + 1'b1;
    assign w_rd_addr = AW'(count_reg[RW-1:0]) * AW'(MAX_HIDDEN) + AW'(j_reg);
    assign pop_ready = (state_reg == ST_IDLE);
    assign issue     = (state_reg == ST_MAC);
    assign out_load  = (state_reg == ST_OUT_LUT) && (!m_valid_reg || m_ready);
    assign done_clear = out_load && at_last_j;

    // sequencer
    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        count_next = count_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop_valid && pop_data.op == OP_ELEM) begin
                    j_next     = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                if (at_last_j) begin
                    state_next = ST_DRAIN;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!s1_valid_reg && !s2_valid_reg) begin
                    if (count_inc >= in_eff) begin
                        count_next = '0;
                        j_next     = '0;
                        state_next = ST_OUT_RD;
                    end else begin
                        count_next = count_inc;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_SUM;
            end
            ST_OUT_SUM: begin
                state_next = ST_OUT_LUT;
            end
            ST_OUT_LUT: begin
                if (out_load) begin
                    if (at_last_j) begin
                        state_next = ST_IDLE;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            j_reg        <= '0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            j_reg        <= j_next;
            count_reg    <= count_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // element latch
    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready && pop_data.op == OP_ELEM) begin
            x_reg <= pop_data.value;
        end
    end

    // weight store
    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready && pop_data.op == OP_WEIGHT) begin
            wmem[pop_data.addr[AW-1:0]] <= pop_data.value;
        end
        w_rd_reg <= wmem[w_rd_addr];
    end

    // bias store
    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready && pop_data.op == OP_BIAS) begin
            bmem[pop_data.addr[HW-1:0]] <= pop_data.value;
        end
        b_rd_reg <= bmem[j_reg];
    end

    // accumulator store, written from the last mac stage
    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            amem[s2_idx_reg] <= acc_hold_reg + 48'(prod_reg);
        end
        a_rd_reg  <= amem[j_reg];
        a_vld_reg <= acc_vld_reg[j_reg];
    end

    // entries not written since the last vector read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn || done_clear) begin
            acc_vld_reg <= '0;
        end else if (s2_valid_reg) begin
            acc_vld_reg[s2_idx_reg] <= 1'b1;
        end
    end

    assign acc_cur = a_vld_reg ? a_rd_reg : 48'd0;

    // mac pipeline: multiply, then add
    always_ff @(posedge aclk) begin
        s1_idx_reg   <= j_reg;
        s2_idx_reg   <= s1_idx_reg;
        prod_reg     <= x_reg * $signed(w_rd_reg);
        acc_hold_reg <= acc_cur;
    end

    // bias add and clamp to the table range
    assign sum   = acc_cur + {{20{b_rd_reg[15]}}, b_rd_reg, 12'd0};
    assign under = sum[47] && !(&sum[46:27]);
    assign over  = !sum[47] && (|sum[46:27]);
    always_comb begin
        if (under) begin
            lut_idx = 8'd0;
        end else if (over) begin
            lut_idx = 8'd255;
        end else begin
            lut_idx = {~sum[27], sum[26:20]};
        end
    end

    always_ff @(posedge aclk) begin
        lut_idx_reg <= lut_idx;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_idx_reg  <= 6'(j_reg);
            m_act_reg  <= SIG_TABLE[lut_idx_reg];
            m_last_reg <= at_last_j;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hidden_index = m_idx_reg;
    assign m_activation   = m_act_reg;
    assign m_last         = m_last_reg;

endmodule

// ===== rtl/dense_layer_sigmoid_unit.sv =====
// dense layer with sigmoid output: each element is applied by the single
// multiply-accumulate sweeping the accumulator store; weight and bias words go
// straight to their stores; a finished vector then emits one word per hidden unit,
// each through the accumulator and bias read and lookup
// reset (synchronous, active low) clears control, the counter and accumulator valid
// bits; weight and bias stores are undefined until written
// depends on dls_pkg, dls_front, dls_queue, dls_back

module dense_layer_sigmoid_unit #(
    parameter int MAX_INPUTS = dls_pkg::DEF_MAX_INPUTS,
    parameter int MAX_HIDDEN = dls_pkg::DEF_MAX_HIDDEN
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    input  logic [7:0]         s_row,
    input  logic [5:0]         s_column,
    input  logic signed [15:0] s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_hidden_index,
    output logic [15:0]        m_activation,
    output logic               m_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [8:0]         cfg_data
);
    import dls_pkg::*;

    cfg_t     cfg_reg;
    logic     push_valid, push_ready, pop_valid, pop_ready;
    q_entry_t push_data, pop_data;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.in_count     <= IN_COUNT_RESET;
            cfg_reg.hidden_count <= HIDDEN_COUNT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_IN_COUNT:     cfg_reg.in_count     <= cfg_data;
                CFG_HIDDEN_COUNT: cfg_reg.hidden_count <= cfg_data[6:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    dls_front #(
        .MAX_INPUTS (MAX_INPUTS),
        .MAX_HIDDEN (MAX_HIDDEN)
    ) u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_action   (s_action),
        .s_row      (s_row),
        .s_column   (s_column),
        .s_value    (s_value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    dls_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    dls_back #(
        .MAX_INPUTS (MAX_INPUTS),
        .MAX_HIDDEN (MAX_HIDDEN)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_data       (pop_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hidden_index (m_hidden_index),
        .m_activation   (m_activation),
        .m_last         (m_last)
    );

endmodule

// ===== rtl/dls_checker.sv =====
// port-level checks on the result channel of the dense layer unit
// depends on dense_layer_sigmoid_unit, attached by bind

module dls_checker #(
    parameter int MAX_HIDDEN = dls_pkg::DEF_MAX_HIDDEN
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [5:0]  m_hidden_index,
    input logic [15:0] m_activation,
    input logic        m_last
);
    // next hidden index expected on the result channel
    logic [5:0] exp_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_idx_reg <= '0;
        end else if (m_valid && m_ready) begin
            exp_idx_reg <= m_last ? 6'd0 : m_hidden_index + 1'b1;
        end
    end

    // no result word right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hidden_index)
            && $stable(m_activation) && $stable(m_last))
        else $error("stalled result word changed");

    // hidden indexes run in order from zero within a vector
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hidden_index == exp_idx_reg)
        else $error("hidden index out of sequence");

    // no index beyond the hidden store
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> {1'b0, m_hidden_index} < 7'(MAX_HIDDEN))
        else $error("hidden index beyond store");

endmodule

bind dense_layer_sigmoid_unit dls_checker #(.MAX_HIDDEN(MAX_HIDDEN)) u_dls_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_hidden_index (m_hidden_index),
    .m_activation   (m_activation),
    .m_last         (m_last)
);

// ===== dv/testbench.sv =====
// self-checking testbench for dense_layer_sigmoid_unit: preloads weights and biases,
// drives directed and random words through several register settings and checks results
// depends on dls_pkg and the dense_layer_sigmoid_unit rtl

module testbench;

    import dls_pkg::*;

    localparam int          N_IN       = 16;
    localparam int          N_HID      = 16;
    localparam logic [1:0]  ACT_NONE   = 2'd3;
    localparam int          IDLE_LIMIT = 4000;
    localparam int          DRAIN_WAIT = 100;
    localparam int          HOLD_LEN   = 400;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         row;
        logic [5:0]         column;
        logic signed [15:0] value;
    } layer_word_t;

    typedef struct packed {
        logic [5:0]  hidden_index;
        logic [15:0] activation;
        logic        last;
    } act_word_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_action = '0;
    logic [7:0]         s_row = '0;
    logic [5:0]         s_column = '0;
    logic signed [15:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [5:0]         m_hidden_index;
    logic [15:0]        m_activation;
    logic               m_last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic [8:0]         cfg_data = '0;

    // handshake flags captured at the rising edge, read at the falling edge
    logic s_acc = 1'b0;
    logic m_acc = 1'b0;
    logic cfg_acc = 1'b0;

    layer_word_t pending_words[$];
    act_word_t   act_expect[$];
    int          err_cnt = 0;
    int          idle_cycles = 0;
    bit          burst = 1'b0;

    // predictor state
    logic [15:0] sig_lut [256];
    logic [15:0] weight_mem [N_IN * N_HID];
    logic [15:0] bias_mem [N_HID];
    logic [47:0] acc_mem [N_HID];
    logic [8:0]  elem_cnt;
    logic [8:0]  in_count_reg;
    logic [6:0]  hidden_count_reg;

    dense_layer_sigmoid_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action), .s_row(s_row),
        .s_column(s_column), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_hidden_index(m_hidden_index),
        .m_activation(m_activation), .m_last(m_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // sigmoid lookup values built with exact integer series for exp
    function automatic void fill_sigmoid_lut();
        longint unsigned one_q40;
        longint unsigned k;
        longint unsigned term;
        longint unsigned e_sum;
        longint unsigned den;
        longint unsigned v;
        one_q40 = 64'd1 << 40;
        for (int i = 0; i < 128; i++) begin
            k = 255 - 2 * i;
            term = one_q40;
            e_sum = term;
            for (int n = 1; n < 200 && term != 0; n++) begin
                term = term * k / (32 * n);
                e_sum += term;
            end
            den = one_q40 + e_sum;
            v = (64'd65535 * one_q40 + den / 2) / den;
            sig_lut[i] = v[15:0];
            sig_lut[255 - i] = 16'(64'd65535 - v);
        end
    endfunction

    function automatic int clamp_count(int raw, int hi);
        if (raw < 1) return 1;
        return (raw > hi) ? hi : raw;
    endfunction

    // sigmoid of accumulator plus bias, clamped to [-8, 8)
    function automatic logic [15:0] sigmoid_of(logic [47:0] acc, logic [15:0] bias);
        logic signed [47:0] sum;
        logic [47:0]        idx;
        sum = acc + {{20{bias[15]}}, bias, 12'd0};
        if (sum < -(48'sd1 <<< 27)) sum = -(48'sd1 <<< 27);
        if (sum > (48'sd1 <<< 27) - 1) sum = (48'sd1 <<< 27) - 1;
        idx = (sum + (48'sd1 <<< 27)) >>> 20;
        return sig_lut[idx[7:0]];
    endfunction

    // one accepted input word through the layer model
    function automatic void predict_layer(layer_word_t w);
        int                 hc;
        int                 r;
        logic signed [31:0] prod;
        act_word_t          res;
        case (w.action)
            ACT_WEIGHT: begin
                if (w.row < N_IN && w.column < N_HID)
                    weight_mem[w.row * N_HID + w.column] = w.value;
            end
            ACT_BIAS: begin
                if (w.column < N_HID) bias_mem[w.column] = w.value;
            end
            ACT_ELEM: begin
                hc = clamp_count(hidden_count_reg, N_HID);
                r = elem_cnt % N_IN;
                for (int j = 0; j < hc; j++) begin
                    prod = w.value * $signed(weight_mem[r * N_HID + j]);
                    acc_mem[j] = acc_mem[j] + {{16{prod[31]}}, prod};
                end
                elem_cnt = elem_cnt + 9'd1;
                if (elem_cnt >= clamp_count(in_count_reg, N_IN)) begin
                    for (int j = 0; j < hc; j++) begin
                        res.hidden_index = 6'(j);
                        res.activation = sigmoid_of(acc_mem[j], bias_mem[j]);
                        res.last = (j + 1 == hc);
                        act_expect.push_back(res);
                    end
                    for (int j = 0; j < N_HID; j++) acc_mem[j] = '0;
                    elem_cnt = '0;
                end
            end
            default: ;
        endcase
    endfunction

    // monitor: predict on accepted words, check results, watchdog
    always @(posedge aclk) begin
        act_word_t exp_w;
        s_acc <= s_valid && s_ready;
        m_acc <= m_valid && m_ready;
        cfg_acc <= cfg_valid && cfg_ready;
        if (aresetn) begin
            if (s_valid && s_ready)
                predict_layer({s_action, s_row, s_column, s_value});
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_IN_COUNT) in_count_reg = cfg_data;
                else hidden_count_reg = cfg_data[6:0];
            end
            if (m_valid && m_ready) begin
                if (act_expect.size() == 0) begin
                    $error("unexpected result word index %0d", m_hidden_index);
                    err_cnt++;
                end else begin
                    exp_w = act_expect.pop_front();
                    if (m_hidden_index !== exp_w.hidden_index) begin
                        $error("hidden_index exp %0d got %0d", exp_w.hidden_index,
                               m_hidden_index);
                        err_cnt++;
                    end
                    if (m_activation !== exp_w.activation) begin
                        $error("activation exp %0d got %0d", exp_w.activation, m_activation);
                        err_cnt++;
                    end
                    if (m_last !== exp_w.last) begin
                        $error("last exp %0d got %0d", exp_w.last, m_last);
                        err_cnt++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // input driver fed from pending_words
    always @(negedge aclk) begin
        static int gap = 0;
        layer_word_t w;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_acc) begin
            s_valid <= 1'b1;
        end else if (gap > 0) begin
            gap--;
            s_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            s_action <= w.action;
            s_row <= w.row;
            s_column <= w.column;
            s_value <= w.value;
            s_valid <= 1'b1;
            gap = burst ? 0 : $urandom_range(0, 14);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge aclk) begin
        static int rx_wait = 0;
        static int hold_left = 0;
        static int rx_words = 0;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_acc) begin
                rx_words++;
                rx_wait = burst ? 0 : $urandom_range(0, 14);
                if (rx_words == 150) hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_word(logic [1:0] act, logic [7:0] r, logic [5:0] c,
                             logic [15:0] v);
        layer_word_t w;
        w = '{action: act, row: r, column: c, value: v};
        pending_words.push_back(w);
    endtask

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'(signed'($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // wait until every word is sent and every result has come back
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || act_expect.size() != 0);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] data);
        wait_drained();
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do @(negedge aclk);
        while (!cfg_acc);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_words(int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 78)
                push_word(ACT_ELEM, 8'($urandom), 6'($urandom), rand_value());
            else if (pick < 88)
                push_word(ACT_WEIGHT, ($urandom_range(0, 5) == 0) ? 8'($urandom)
                          : 8'($urandom_range(0, N_IN - 1)),
                          ($urandom_range(0, 5) == 0) ? 6'($urandom)
                          : 6'($urandom_range(0, N_HID - 1)), rand_value());
            else if (pick < 95)
                push_word(ACT_BIAS, 8'($urandom), 6'($urandom), rand_value());
            else
                push_word(ACT_NONE, 8'($urandom), 6'($urandom), rand_value());
        end
    endtask

    initial begin
        fill_sigmoid_lut();
        for (int j = 0; j < N_HID; j++) acc_mem[j] = '0;
        elem_cnt = '0;
        in_count_reg = IN_COUNT_RESET;
        hidden_count_reg = HIDDEN_COUNT_RESET;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // preload the whole weight and bias store so no read hits an unwritten entry
        burst = 1'b1;
        for (int r = 0; r < N_IN; r++)
            for (int c = 0; c < N_HID; c++)
                push_word(ACT_WEIGHT, 8'(r), 6'(c), rand_value());
        for (int c = 0; c < N_HID; c++)
            push_word(ACT_BIAS, 8'($urandom), 6'(c), rand_value());
        wait_drained();
        burst = 1'b0;

        // directed: ignored writes, unknown action, extreme elements and saturation
        push_word(ACT_WEIGHT, 8'd255, 6'd63, 16'h7fff);
        push_word(ACT_WEIGHT, 8'd3, 6'd63, 16'h8000);
        push_word(ACT_WEIGHT, 8'd16, 6'd0, 16'h8000);
        push_word(ACT_BIAS, 8'd0, 6'd63, 16'h7fff);
        push_word(ACT_BIAS, 8'd255, 6'd0, 16'h7fff);
        push_word(ACT_BIAS, 8'd0, 6'd15, 16'h8000);
        push_word(ACT_NONE, 8'hff, 6'h3f, 16'hffff);
        push_word(ACT_WEIGHT, 8'd0, 6'd0, 16'h7fff);
        push_word(ACT_WEIGHT, 8'd15, 6'd15, 16'h8000);
        for (int i = 0; i < N_IN; i++)
            push_word(ACT_ELEM, 8'(i * 17), 6'(i * 5),
                      (i % 2) ? 16'h8000 : 16'h7fff);

        // smallest sizes
        write_reg(CFG_IN_COUNT, 9'd1);
        write_reg(CFG_HIDDEN_COUNT, 9'd1);
        push_word(ACT_ELEM, 8'd0, 6'd0, 16'h0000);
        push_word(ACT_ELEM, 8'd0, 6'd0, 16'hffff);
        random_words(20);

        // zero registers saturate up to one
        write_reg(CFG_IN_COUNT, 9'd0);
        write_reg(CFG_HIDDEN_COUNT, 9'd0);
        random_words(15);

        // oversized registers saturate down to the store size
        write_reg(CFG_IN_COUNT, 9'd511);
        write_reg(CFG_HIDDEN_COUNT, 9'd127);
        random_words(30);

        // partial vector left open, then in_count lowered below the count
        write_reg(CFG_IN_COUNT, 9'd16);
        write_reg(CFG_HIDDEN_COUNT, 9'd64);
        for (int i = 0; i < 5; i++)
            push_word(ACT_ELEM, 8'($urandom), 6'($urandom), rand_value());
        write_reg(CFG_IN_COUNT, 9'd3);
        write_reg(CFG_HIDDEN_COUNT, 9'd7);
        push_word(ACT_ELEM, 8'd0, 6'd0, rand_value());
        random_words(25);

        // no idling, then a long run with in_count saturated to the store size
        burst = 1'b1;
        write_reg(CFG_IN_COUNT, 9'd2);
        write_reg(CFG_HIDDEN_COUNT, 9'd16);
        random_words(25);
        wait_drained();
        burst = 1'b0;
        write_reg(CFG_IN_COUNT, 9'd300);
        write_reg(CFG_HIDDEN_COUNT, 9'd11);
        random_words(35);

        wait_drained();
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dls_pkg.sv
rtl/dls_queue.sv
rtl/dls_front.sv
rtl/dls_back.sv
rtl/dense_layer_sigmoid_unit.sv
rtl/dls_checker.sv
dv/testbench.sv
